// ===== rtl/core/refcounted_block_allocator_defines.svh =====
// Assertion macros shared by the allocator's checker.
`ifndef REFCOUNTED_BLOCK_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCBA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCBA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rcba_pkg.sv =====
`timescale 1ns / 1ps

package rcba_pkg;

  // Field widths of the request, response and configuration ports.
  localparam int ID_W     = 10;
  localparam int BC_W     = 11;
  localparam int FUNC_W   = 3;
  localparam int STATUS_W = 3;
  localparam int OCNT_W   = 8;

  // Largest pool that a block id can address.
  localparam int ID_REACH = 1024;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_FREE    = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RETAIN  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 3'd4;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_ALLOC = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd4;

endpackage

// ===== rtl/core/rcba_ram.sv =====
`timescale 1ns / 1ps

module rcba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port; a read in the cycle of a
  // write to the same entry returns the old data.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/refcounted_block_allocator.sv =====
`timescale 1ns / 1ps
// Reference-counted block allocator.
// Requests (func_i, block_id_i) arrive on a valid/ready channel and each one
// yields exactly one response (status_o, result_block_o, ref_cnt_o,
// allocated_o) on a second valid/ready channel, in request order.
// A request is taken at the edge where in_valid_i and in_ready_o are high;
// it is held in the execute stage register, and its response is written
// into the response register once that is free and is taken from there.
// The free stack and the count table live in two memories with one read and
// one write port each. Every request reads both and writes back what it changes; the
// write of one request is forwarded into the read of the next, so one request
// is taken per cycle as long as the response side keeps up.
// When the response register is full and out_ready_i is low, a request in the
// execute stage waits, and in_ready_o is low until the response is taken.
// After reset, and after every write on cfg_we_i/cfg_wdata_i, the block count
// is clamped to the pool size and both memories are rebuilt in a clearing
// pass over all min(BLOCK_TOTAL, 1024) entries (1024 by default), during which
// in_ready_o is low.

module refcounted_block_allocator #(
  parameter int BLOCK_TOTAL = 1024,
  parameter int MAX_REF     = 255
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rcba_pkg::BC_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rcba_pkg::FUNC_W-1:0]   func_i,
  input  logic [rcba_pkg::ID_W-1:0]     block_id_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rcba_pkg::STATUS_W-1:0] status_o,
  output logic [rcba_pkg::ID_W-1:0]     result_block_o,
  output logic [rcba_pkg::OCNT_W-1:0]   ref_cnt_o,
  output logic                          allocated_o
);

  localparam int CAP  = (BLOCK_TOTAL < rcba_pkg::ID_REACH) ? BLOCK_TOTAL : rcba_pkg::ID_REACH;
  localparam int AW   = (CAP > 1) ? $clog2(CAP) : 1;
  localparam int TW   = $clog2(CAP + 1);
  localparam int CW   = $clog2(MAX_REF + 1);
  localparam int CWX  = CW + rcba_pkg::OCNT_W;
  localparam int IDW  = rcba_pkg::ID_W;
  localparam int BCW  = rcba_pkg::BC_W;

  // Configuration and clearing pass.
  logic [BCW-1:0] block_count_q, block_count_d;
  logic           clr_active_q, clr_active_d;
  logic [AW-1:0]  clr_idx_q, clr_idx_d;
  logic [TW-1:0]  top_q, top_d;
  logic [BCW-1:0] cfg_clamped;
  logic [BCW-1:0] clr_stack_val;

  // Execute stage.
  logic                          ex_valid_q, ex_valid_d;
  logic [rcba_pkg::FUNC_W-1:0]   ex_func_q;
  logic [IDW-1:0]                ex_id_q;
  logic                          fwd_ref_hit_q, fwd_ref_hit_d;
  logic [CW-1:0]                 fwd_ref_val_q;
  logic                          fwd_stk_hit_q, fwd_stk_hit_d;
  logic [IDW-1:0]                fwd_stk_val_q;
  logic                          ex_fire, in_fire;

  // Response register.
  logic                          out_valid_q, out_valid_d;
  logic [rcba_pkg::STATUS_W-1:0] out_status_q;
  logic [IDW-1:0]                out_blk_q;
  logic [rcba_pkg::OCNT_W-1:0]   out_cnt_q;
  logic                          out_alloc_q;

  // Memory ports.
  logic           ref_mem_we, stk_mem_we, mem_re;
  logic [AW-1:0]  ref_mem_waddr, stk_mem_waddr, ref_mem_raddr, stk_mem_raddr;
  logic [CW-1:0]  ref_mem_wdata, ref_rdata;
  logic [IDW-1:0] stk_mem_wdata, stk_rdata;

  // Result of the execute stage.
  logic [CW-1:0]                 cnt, res_cnt, ref_wdata;
  logic [IDW-1:0]                stk, res_blk, pop_blk;
  logic [rcba_pkg::STATUS_W-1:0] res_status;
  logic                          ref_we, do_push, do_pop, push_ok;
  logic [AW-1:0]                 ref_waddr;
  logic [CWX-1:0]                res_cnt_ext;
  logic                          id_in_range;

  // The count table and the free stack.
  rcba_ram #(.WIDTH(CW), .DEPTH(CAP)) u_ref_ram (
    .clk_i   (clk_i),
    .we_i    (ref_mem_we),
    .waddr_i (ref_mem_waddr),
    .wdata_i (ref_mem_wdata),
    .re_i    (mem_re),
    .raddr_i (ref_mem_raddr),
    .rdata_o (ref_rdata)
  );

  rcba_ram #(.WIDTH(IDW), .DEPTH(CAP)) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_mem_we),
    .waddr_i (stk_mem_waddr),
    .wdata_i (stk_mem_wdata),
    .re_i    (mem_re),
    .raddr_i (stk_mem_raddr),
    .rdata_o (stk_rdata)
  );

  // Operands, with the previous request's writes forwarded.
  assign cnt = fwd_ref_hit_q ? fwd_ref_val_q : ref_rdata;
  assign stk = fwd_stk_hit_q ? fwd_stk_val_q : stk_rdata;
  assign pop_blk = ({1'b0, stk} >= BCW'(CAP)) ? '0 : stk;
  assign id_in_range = {1'b0, ex_id_q} < block_count_q;

  // Execute one operation.
  always_comb begin
    res_status = rcba_pkg::ST_OK;
    res_blk    = ex_id_q;
    res_cnt    = cnt;
    ref_we     = 1'b0;
    ref_waddr  = ex_id_q[AW-1:0];
    ref_wdata  = cnt;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    if (ex_func_q == rcba_pkg::FUNC_ALLOC) begin
      if (top_q == '0) begin
        res_status = rcba_pkg::ST_EXHAUSTED;
        res_blk    = '0;
        res_cnt    = '0;
      end else begin
        do_pop    = 1'b1;
        res_blk   = pop_blk;
        res_cnt   = CW'(1);
        ref_we    = 1'b1;
        ref_waddr = pop_blk[AW-1:0];
        ref_wdata = CW'(1);
      end
    end else if (!id_in_range) begin
      res_status = rcba_pkg::ST_RANGE;
      res_cnt    = '0;
    end else if ((ex_func_q inside {rcba_pkg::FUNC_FREE, rcba_pkg::FUNC_RETAIN,
                                    rcba_pkg::FUNC_RELEASE}) && cnt == '0) begin
      res_status = rcba_pkg::ST_NOT_ALLOC;
      res_cnt    = '0;
    end else begin
      case (ex_func_q)
        rcba_pkg::FUNC_FREE: begin
          ref_we    = 1'b1;
          ref_wdata = '0;
          res_cnt   = '0;
          do_push   = 1'b1;
        end
        rcba_pkg::FUNC_RETAIN: begin
          if (cnt >= CW'(MAX_REF)) begin
            res_status = rcba_pkg::ST_OVERFLOW;
          end else begin
            ref_we    = 1'b1;
            ref_wdata = cnt + CW'(1);
            res_cnt   = cnt + CW'(1);
          end
        end
        rcba_pkg::FUNC_RELEASE: begin
          ref_we    = 1'b1;
          ref_wdata = cnt - CW'(1);
          res_cnt   = cnt - CW'(1);
          do_push   = (cnt == CW'(1));
        end
        default: begin
          res_cnt = cnt;
        end
      endcase
    end
  end

  // A push onto a full stack is dropped.
  assign push_ok = do_push && (top_q < TW'(CAP));
  assign res_cnt_ext = CWX'(res_cnt);

  // Handshakes.
  assign ex_fire    = ex_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !clr_active_q && (!ex_valid_q || ex_fire);
  assign in_fire    = in_valid_i && in_ready_o;

  // Clamp of a written block count.
  assign cfg_clamped   = (cfg_wdata_i > BCW'(CAP)) ? BCW'(CAP) : cfg_wdata_i;
  assign clr_stack_val = block_count_q - BCW'(1) - BCW'(clr_idx_q);

  // Stack pointer, clearing pass and pipeline control.
  always_comb begin
    block_count_d = block_count_q;
    clr_active_d  = clr_active_q;
    clr_idx_d     = clr_idx_q;
    top_d         = top_q;
    if (clr_active_q) begin
      clr_idx_d = clr_idx_q + AW'(1);
      if (clr_idx_q == AW'(CAP - 1)) begin
        clr_active_d = 1'b0;
      end
    end
    if (ex_fire && do_pop) begin
      top_d = top_q - TW'(1);
    end else if (ex_fire && push_ok) begin
      top_d = top_q + TW'(1);
    end
    if (cfg_we_i) begin
      block_count_d = cfg_clamped;
      clr_active_d  = 1'b1;
      clr_idx_d     = '0;
      top_d         = TW'(cfg_clamped);
    end
  end

  always_comb begin
    ex_valid_d = ex_valid_q;
    if (in_fire) begin
      ex_valid_d = 1'b1;
    end else if (ex_fire) begin
      ex_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (ex_fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Forwarding of this cycle's writes into the next request's reads.
  assign fwd_ref_hit_d = ex_fire && ref_we && (ref_waddr == block_id_i[AW-1:0]);
  assign fwd_stk_hit_d = ex_fire && push_ok;

  // Memory port selection.
  assign mem_re        = in_fire;
  assign ref_mem_raddr = block_id_i[AW-1:0];
  assign stk_mem_raddr = AW'(top_d - TW'(1));
  assign ref_mem_we    = clr_active_q || (ex_fire && ref_we);
  assign ref_mem_waddr = clr_active_q ? clr_idx_q : ref_waddr;
  assign ref_mem_wdata = clr_active_q ? '0 : ref_wdata;
  assign stk_mem_we    = clr_active_q || (ex_fire && push_ok);
  assign stk_mem_waddr = clr_active_q ? clr_idx_q : top_q[AW-1:0];
  assign stk_mem_wdata = clr_active_q ? clr_stack_val[IDW-1:0] : ex_id_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= BCW'(CAP);
      clr_active_q  <= 1'b1;
      clr_idx_q     <= '0;
      top_q         <= TW'(CAP);
      ex_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      fwd_ref_hit_q <= 1'b0;
      fwd_stk_hit_q <= 1'b0;
    end else begin
      block_count_q <= block_count_d;
      clr_active_q  <= clr_active_d;
      clr_idx_q     <= clr_idx_d;
      top_q         <= top_d;
      ex_valid_q    <= ex_valid_d;
      out_valid_q   <= out_valid_d;
      if (in_fire) begin
        fwd_ref_hit_q <= fwd_ref_hit_d;
        fwd_stk_hit_q <= fwd_stk_hit_d;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      ex_func_q     <= func_i;
      ex_id_q       <= block_id_i;
      fwd_ref_val_q <= ref_wdata;
      fwd_stk_val_q <= ex_id_q;
    end
    if (ex_fire) begin
      out_status_q <= res_status;
      out_blk_q    <= res_blk;
      out_cnt_q    <= res_cnt_ext[rcba_pkg::OCNT_W-1:0];
      out_alloc_q  <= (res_cnt != '0);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_status_q;
  assign result_block_o = out_blk_q;
  assign ref_cnt_o      = out_cnt_q;
  assign allocated_o    = out_alloc_q;

endmodule

// ===== rtl/core/rcba_checker.sv =====
`timescale 1ns / 1ps
`include "refcounted_block_allocator_defines.svh"

module rcba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          cfg_we_i,
  input logic                          in_ready_o,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [rcba_pkg::STATUS_W-1:0] status_o,
  input logic [rcba_pkg::ID_W-1:0]     result_block_o,
  input logic [rcba_pkg::OCNT_W-1:0]   ref_cnt_o,
  input logic                          allocated_o
);

  // A pending response stays until it is transferred.
  `RCBA_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o, "response dropped while stalled")

  // A block count write starts a rebuild, which takes no requests.
  `RCBA_ASSERT_NXT(a_cfg_rebuild, clk_i, rst_ni, cfg_we_i, !in_ready_o, "request taken during rebuild")

  // An exhausted pool reports an all-zero response.
  `RCBA_ASSERT_IMP(a_exhausted, clk_i, rst_ni, out_valid_o && status_o == rcba_pkg::ST_EXHAUSTED, result_block_o == '0 && ref_cnt_o == '0 && !allocated_o, "exhausted response not zero")

  // Range and not-allocated errors report a zero count.
  `RCBA_ASSERT_IMP(a_err_zero, clk_i, rst_ni, out_valid_o && (status_o == rcba_pkg::ST_RANGE || status_o == rcba_pkg::ST_NOT_ALLOC), ref_cnt_o == '0 && !allocated_o, "error response has a count")

  // A saturated count belongs to an allocated block.
  `RCBA_ASSERT_IMP(a_overflow, clk_i, rst_ni, out_valid_o && status_o == rcba_pkg::ST_OVERFLOW, allocated_o, "overflow on a free block")

endmodule

bind refcounted_block_allocator rcba_checker u_rcba_checker (.*);
